// ----- design/vsnq_pkg.sv -----
// Shared types, codes and arithmetic helpers for the voxel surface normal quantizer.
`timescale 1ns / 1ps
`default_nettype none

package vsnq_pkg;

   typedef logic [25:0]        mask_type;
   typedef logic [3:0]         code_type;
   typedef logic [4:0]         count_type;
   typedef logic [3:0]         pcount_type;
   typedef logic signed [4:0]  axis_type;
   typedef logic signed [5:0]  pair_type;
   typedef logic signed [7:0]  score_type;
   typedef score_type [7:0]    score_vec_type;

   typedef struct packed {
      score_type score;
      code_type  idx;
   } pick_type;

   localparam count_type FULL_COUNT    = 5'd26;
   localparam code_type  DIR_NONE      = 4'd0;
   localparam code_type  DIR_CARD_BASE = 4'd8;
   localparam code_type  DIR_LAST      = 4'd14;

   function automatic pcount_type popcount9(input logic [8:0] v);
      pcount_type n;
      n = '0;
      for (int i = 0; i < 9; i++) begin
         n = n + {3'b000, v[i]};
      end
      return n;
   endfunction

   // Neighbors on the negative side push the sum positive.
   function automatic axis_type axis_sum(input logic [8:0] neg, input logic [8:0] pos);
      axis_type a;
      axis_type b;
      a = $signed({1'b0, popcount9(neg)});
      b = $signed({1'b0, popcount9(pos)});
      return a - b;
   endfunction

   function automatic pair_type pair_add(input axis_type a, input axis_type b);
      return $signed({a[4], a}) + $signed({b[4], b});
   endfunction

   function automatic pair_type pair_sub(input axis_type a, input axis_type b);
      return $signed({a[4], a}) - $signed({b[4], b});
   endfunction

   // 0.7 scaled by ten
   function automatic score_type scale7(input pair_type a);
      score_type e;
      e = $signed({{2{a[5]}}, a});
      return (e <<< 3) - e;
   endfunction

   function automatic score_type scale10(input axis_type a);
      score_type e;
      e = $signed({{3{a[4]}}, a});
      return (e <<< 3) + (e <<< 1);
   endfunction

endpackage

`default_nettype wire

// ----- design/vsnq_argmax.sv -----
// First strictly largest positive score among eight candidates.
`timescale 1ns / 1ps
`default_nettype none

module vsnq_argmax (
   input  vsnq_pkg::score_vec_type scores,
   output vsnq_pkg::pick_type      pick
);
   import vsnq_pkg::*;

   score_type best;
   code_type  idx;

   always_comb begin
      best = '0;
      idx  = DIR_NONE;
      for (int i = 0; i < 8; i++) begin
         if ($signed(scores[i]) > $signed(best)) begin
            best = scores[i];
            idx  = code_type'(i + 1);
         end
      end
      pick.score = best;
      pick.idx   = idx;
   end

endmodule

`default_nettype wire

// ----- design/voxel_surface_normal_quantizer.sv -----
// Top level of the voxel surface normal quantizer.
`timescale 1ns / 1ps
`default_nettype none

// Each transfer on req_ carries the 26-bit occupancy mask of one voxel's
// neighbors; each transfer on rsp_ returns the quantized normal direction
// (0 none, 1-8 up/down diagonals, 9-14 cardinal), the neighbor count and the
// interior flag, one result per request, in order. The block takes one item
// every cycle while rsp_ready stays high: four register stages (axis sums and
// count, scaled dot products, per-group best pick, final pick into the output
// register) each advance whenever the stage after them is empty or moving.
// The request transfer loads the first stage and the item moves on through
// the later stages to the output register, which drives rsp_valid; a stalled
// rsp_ side holds items in place without loss. csr_write_data bit 0 sets
// diagonal_enable (reset 1); write it only while no item is in flight.
module voxel_surface_normal_quantizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  vsnq_pkg::mask_type req_neighbor_mask,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vsnq_pkg::code_type  rsp_direction_code,
   output vsnq_pkg::count_type rsp_neighbor_count,
   output logic               rsp_interior,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);
   import vsnq_pkg::*;

   // configuration
   logic diag_en_ff;

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en2, en3, en4;

   // stage 1: axis sums and count
   axis_type  s1_sx_in, s1_sy_in, s1_sz_in;
   axis_type  s1_sx_ff, s1_sy_ff, s1_sz_ff;
   count_type s1_count_in, s1_count_ff;

   // stage 2: scaled dot products
   score_vec_type s2_diag_in, s2_card_in;
   score_vec_type s2_diag_ff, s2_card_ff;
   count_type     s2_count_ff;

   // stage 3: best per group
   pick_type  s3_diag_in, s3_card_in;
   pick_type  s3_diag_ff, s3_card_ff;
   count_type s3_count_ff;

   // stage 4: output register
   code_type  s4_code_in, s4_code_ff;
   count_type s4_count_ff;
   score_type diag_best;
   code_type  diag_idx;

   // Advance a stage when the stage after it is empty or draining.
   assign en4       = !v4_ff || rsp_ready;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign req_ready = !v1_ff || en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         diag_en_ff <= 1'b1;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            diag_en_ff <= csr_write_data;
         end
         if (req_ready) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // Stage 1: split the mask by axis side. Bits 0-8 are dx=-1, 9-16 dx=0,
   // 17-25 dx=+1; within each group dy runs outer and dz inner.
   always_comb begin
      s1_sx_in = axis_sum(req_neighbor_mask[8:0], req_neighbor_mask[25:17]);
      s1_sy_in = axis_sum(
         {req_neighbor_mask[0],  req_neighbor_mask[1],  req_neighbor_mask[2],
          req_neighbor_mask[9],  req_neighbor_mask[10], req_neighbor_mask[11],
          req_neighbor_mask[17], req_neighbor_mask[18], req_neighbor_mask[19]},
         {req_neighbor_mask[6],  req_neighbor_mask[7],  req_neighbor_mask[8],
          req_neighbor_mask[14], req_neighbor_mask[15], req_neighbor_mask[16],
          req_neighbor_mask[23], req_neighbor_mask[24], req_neighbor_mask[25]});
      s1_sz_in = axis_sum(
         {req_neighbor_mask[0],  req_neighbor_mask[3],  req_neighbor_mask[6],
          req_neighbor_mask[9],  req_neighbor_mask[12], req_neighbor_mask[14],
          req_neighbor_mask[17], req_neighbor_mask[20], req_neighbor_mask[23]},
         {req_neighbor_mask[2],  req_neighbor_mask[5],  req_neighbor_mask[8],
          req_neighbor_mask[11], req_neighbor_mask[13], req_neighbor_mask[16],
          req_neighbor_mask[19], req_neighbor_mask[22], req_neighbor_mask[25]});
      s1_count_in = count_type'(popcount9(req_neighbor_mask[8:0]))
                  + count_type'(popcount9({1'b0, req_neighbor_mask[16:9]}))
                  + count_type'(popcount9(req_neighbor_mask[25:17]));
   end

   // Stage 2: dot products scaled by ten, diagonals in test order.
   always_comb begin
      s2_diag_in[0] = scale7(pair_add(s1_sx_ff, s1_sz_ff));
      s2_diag_in[1] = scale7(pair_sub(s1_sz_ff, s1_sx_ff));
      s2_diag_in[2] = scale7(pair_add(s1_sy_ff, s1_sz_ff));
      s2_diag_in[3] = scale7(pair_sub(s1_sz_ff, s1_sy_ff));
      s2_diag_in[4] = scale7(pair_sub(s1_sx_ff, s1_sz_ff));
      s2_diag_in[5] = -scale7(pair_add(s1_sx_ff, s1_sz_ff));
      s2_diag_in[6] = scale7(pair_sub(s1_sy_ff, s1_sz_ff));
      s2_diag_in[7] = -scale7(pair_add(s1_sy_ff, s1_sz_ff));
      s2_card_in[0] = scale10(s1_sy_ff);
      s2_card_in[1] = -scale10(s1_sy_ff);
      s2_card_in[2] = scale10(s1_sx_ff);
      s2_card_in[3] = -scale10(s1_sx_ff);
      s2_card_in[4] = scale10(s1_sz_ff);
      s2_card_in[5] = -scale10(s1_sz_ff);
      // Zero never wins a strict compare, so the spare slots drop out.
      s2_card_in[6] = '0;
      s2_card_in[7] = '0;
   end

   // Stage 3: pick within each group.
   vsnq_argmax u_diag_pick (
      .scores (s2_diag_ff),
      .pick   (s3_diag_in)
   );

   vsnq_argmax u_card_pick (
      .scores (s2_card_ff),
      .pick   (s3_card_in)
   );

   // Stage 4: diagonals come first in test order, so a cardinal wins only
   // when strictly greater.
   always_comb begin
      diag_best = diag_en_ff ? s3_diag_ff.score : '0;
      diag_idx  = diag_en_ff ? s3_diag_ff.idx : DIR_NONE;
      if ($signed(s3_card_ff.score) > $signed(diag_best)) begin
         s4_code_in = s3_card_ff.idx + DIR_CARD_BASE;
      end else begin
         s4_code_in = diag_idx;
      end
   end

   // Payload registers: load with their stage.
   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_sx_ff    <= s1_sx_in;
         s1_sy_ff    <= s1_sy_in;
         s1_sz_ff    <= s1_sz_in;
         s1_count_ff <= s1_count_in;
      end
      if (en2) begin
         s2_diag_ff  <= s2_diag_in;
         s2_card_ff  <= s2_card_in;
         s2_count_ff <= s1_count_ff;
      end
      if (en3) begin
         s3_diag_ff  <= s3_diag_in;
         s3_card_ff  <= s3_card_in;
         s3_count_ff <= s2_count_ff;
      end
      if (en4) begin
         s4_code_ff  <= s4_code_in;
         s4_count_ff <= s3_count_ff;
      end
   end

   assign rsp_valid          = v4_ff;
   assign rsp_direction_code = s4_code_ff;
   assign rsp_neighbor_count = s4_count_ff;
   assign rsp_interior       = (s4_count_ff == FULL_COUNT);

   // A fully surrounded voxel cancels out in every axis.
   a_interior_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_interior |-> rsp_direction_code == DIR_NONE)
      else $error("interior voxel produced a direction");

   a_empty_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_neighbor_count == 5'd0 |-> rsp_direction_code == DIR_NONE)
      else $error("voxel without neighbors produced a direction");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_direction_code <= DIR_LAST && rsp_neighbor_count <= FULL_COUNT)
      else $error("result out of range");

   a_no_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !diag_en_ff |->
         rsp_direction_code == DIR_NONE || rsp_direction_code > DIR_CARD_BASE)
      else $error("diagonal chosen while diagonals disabled");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && v4_ff && !rsp_ready |=> v3_ff && $stable(s3_count_ff))
      else $error("stage 3 item lost under stall");

endmodule

`default_nettype wire
